// ----- sv/fpa_pkg.sv -----
package fpa_pkg;

    localparam int unsigned DATA_W          = 32;
    localparam int unsigned FRAC_BITS_DEF   = 8;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned OUT_DEPTH       = 2;

    typedef enum logic [3:0] {
        MODE_ADD  = 4'd0,
        MODE_SUB  = 4'd1,
        MODE_MUL  = 4'd2,
        MODE_DIV  = 4'd3,
        MODE_GT   = 4'd4,
        MODE_LT   = 4'd5,
        MODE_GE   = 4'd6,
        MODE_LE   = 4'd7,
        MODE_EQ   = 4'd8,
        MODE_NE   = 4'd9,
        MODE_MIN  = 4'd10,
        MODE_MAX  = 4'd11,
        MODE_INC  = 4'd12,
        MODE_DEC  = 4'd13,
        MODE_ITOF = 4'd14,
        MODE_FTOI = 4'd15
    } t_mode;

    typedef enum logic [1:0] {
        UNIT_ALU = 2'd0,
        UNIT_MUL = 2'd1,
        UNIT_DIV = 2'd2
    } t_unit;

    // classified word handed from the front to the back
    typedef struct packed {
        t_mode                    mode;
        t_unit                    unit;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic [DATA_W-1:0]        a_mag;
        logic [DATA_W-1:0]        b_mag;
        logic                     neg;
        logic                     dz;
    } t_op;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     flag;
        logic                     dz;
    } t_res;

endpackage

// ----- sv/fpa_queue.sv -----
module fpa_queue #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("word pushed into a full queue");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |=> !o_empty)
        else $error("queue empty after a push");

endmodule

// ----- sv/fpa_front.sv -----
module fpa_front
    import fpa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [3:0]               i_mode,
    input  logic signed [DATA_W-1:0] i_operand_a,
    input  logic signed [DATA_W-1:0] i_operand_b,
    output logic                     o_push,
    output t_op                      o_op,
    input  logic                     i_q_full
);

    logic r_vld;
    t_op  r_op;
    t_op  n_op;
    logic accept;

    assign o_full = r_vld && i_q_full;
    assign accept = i_push && !o_full;
    assign o_push = r_vld && !i_q_full;
    assign o_op   = r_op;

    always_comb begin
        n_op       = '0;
        n_op.mode  = t_mode'(i_mode);
        n_op.a     = i_operand_a;
        n_op.b     = i_operand_b;
        n_op.a_mag = i_operand_a[DATA_W-1] ? (~i_operand_a) + 1'b1 : i_operand_a;
        n_op.b_mag = i_operand_b[DATA_W-1] ? (~i_operand_b) + 1'b1 : i_operand_b;
        n_op.neg   = i_operand_a[DATA_W-1] ^ i_operand_b[DATA_W-1];
        unique case (t_mode'(i_mode))
            MODE_MUL: n_op.unit = UNIT_MUL;
            MODE_DIV: n_op.unit = UNIT_DIV;
            default:  n_op.unit = UNIT_ALU;
        endcase
        n_op.dz = (t_mode'(i_mode) == MODE_DIV) && (i_operand_b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

endmodule

// ----- sv/fpa_back.sv -----
module fpa_back
    import fpa_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_op  i_op,
    output logic o_pop,
    output logic o_push,
    output t_res o_res,
    input  logic i_out_full
);

    // numerator |a| << FRAC_BITS, one quotient bit per stage
    localparam int unsigned NUM_W = DATA_W + FRAC_BITS;

    typedef struct packed {
        logic                     vld;
        t_unit                    unit;
        logic signed [DATA_W-1:0] res;
        logic                     flag;
        logic                     dz;
        logic                     neg;
        logic [DATA_W-1:0]        rem;
        logic [NUM_W-1:0]         nq;
        logic [DATA_W-1:0]        dvs;
    } t_stg;

    function automatic t_stg div_step(t_stg s);
        logic [DATA_W:0] trial;
        logic            q;
        t_stg            o;
        o     = s;
        trial = {s.rem, s.nq[NUM_W-1]};
        q     = (trial >= {1'b0, s.dvs});
        o.rem = q ? DATA_W'(trial - {1'b0, s.dvs}) : trial[DATA_W-1:0];
        o.nq  = {s.nq[NUM_W-2:0], q};
        return o;
    endfunction

    t_stg                     r_stg [NUM_W+1];
    t_stg                     n_stg [NUM_W+1];
    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [2*DATA_W-1:0] prod_c;
    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic signed [DATA_W-1:0] alu_res;
    logic                     alu_flag;
    logic [DATA_W-1:0]        quot;
    logic                     adv;

    assign op_a   = i_op.a;
    assign op_b   = i_op.b;
    assign prod_c = op_a * op_b;

    assign adv    = !(r_stg[NUM_W].vld && i_out_full);
    assign o_pop  = adv && !i_empty;
    assign o_push = adv && r_stg[NUM_W].vld;

    always_comb begin
        alu_res  = '0;
        alu_flag = 1'b0;
        unique case (i_op.mode)
            MODE_ADD:  alu_res  = op_a + op_b;
            MODE_SUB:  alu_res  = op_a - op_b;
            MODE_MUL:  alu_res  = '0;
            MODE_DIV:  alu_res  = '0;
            MODE_GT:   alu_flag = (op_a > op_b);
            MODE_LT:   alu_flag = (op_a < op_b);
            MODE_GE:   alu_flag = (op_a >= op_b);
            MODE_LE:   alu_flag = (op_a <= op_b);
            MODE_EQ:   alu_flag = (op_a == op_b);
            MODE_NE:   alu_flag = (op_a != op_b);
            MODE_MIN:  alu_res  = (op_a > op_b) ? op_b : op_a;
            MODE_MAX:  alu_res  = (op_a < op_b) ? op_b : op_a;
            MODE_INC:  alu_res  = op_a + DATA_W'(1);
            MODE_DEC:  alu_res  = op_a - DATA_W'(1);
            MODE_ITOF: alu_res  = op_a <<< FRAC_BITS;
            MODE_FTOI: alu_res  = op_a >>> FRAC_BITS;
        endcase
    end

    always_comb begin
        n_stg[0].vld  = !i_empty;
        n_stg[0].unit = i_op.unit;
        n_stg[0].res  = alu_res;
        n_stg[0].flag = alu_flag;
        n_stg[0].dz   = i_op.dz;
        n_stg[0].neg  = i_op.neg;
        n_stg[0].rem  = '0;
        n_stg[0].nq   = {i_op.a_mag, {FRAC_BITS{1'b0}}};
        n_stg[0].dvs  = i_op.b_mag;
        for (int k = 1; k <= NUM_W; k++) begin
            n_stg[k] = div_step(r_stg[k-1]);
        end
        // product leaves its register in step with stage zero
        if (r_stg[0].unit == UNIT_MUL) begin
            n_stg[1].res = r_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NUM_W; k++) begin
                r_stg[k].vld <= 1'b0;
            end
        end else if (adv) begin
            for (int k = 0; k <= NUM_W; k++) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod <= prod_c;
        end
    end

    assign quot = r_stg[NUM_W].nq[DATA_W-1:0];

    always_comb begin
        o_res.flag = r_stg[NUM_W].flag;
        o_res.dz   = r_stg[NUM_W].dz;
        if (r_stg[NUM_W].unit == UNIT_DIV) begin
            if (r_stg[NUM_W].dz) begin
                o_res.result = '0;
            end else begin
                o_res.result = r_stg[NUM_W].neg ? (~quot) + 1'b1 : quot;
            end
        end else begin
            o_res.result = r_stg[NUM_W].res;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stg[NUM_W].vld && !adv) |=> $stable(r_stg[NUM_W]))
        else $error("last stage changed while stalled");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.dz) |-> (o_res.result == '0 && r_stg[NUM_W].unit == UNIT_DIV))
        else $error("divide by zero word with nonzero result");

    a_flag_alu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.flag) |-> (r_stg[NUM_W].unit == UNIT_ALU))
        else $error("compare flag on a multiply or divide word");

endmodule

// ----- sv/fixed_point_alu.sv -----
// channel   | handshake        | payload
// ----------+------------------+--------------------------------------------
// operation | push / full      | i_mode, i_operand_a, i_operand_b
// result    | empty / pop      | o_result, o_flag, o_div_by_zero
//
// one operation accepted per cycle while full is low
// the restoring divider computes one quotient bit per pipeline stage
// all operations run through the same pipeline, so results leave in order
// synchronous active-low reset empties both queues and the pipeline
// a full result queue freezes the back pipeline; the front queue absorbs input
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [3:0]               i_mode,
    input  logic signed [DATA_W-1:0] i_operand_a,
    input  logic signed [DATA_W-1:0] i_operand_b,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [DATA_W-1:0] o_result,
    output logic                     o_flag,
    output logic                     o_div_by_zero
);

    t_op  front_op;
    t_op  back_op;
    logic front_push;
    logic mid_full;
    logic mid_empty;
    logic back_pop;
    logic back_push;
    t_res back_res;
    t_res out_res;
    logic out_full;

    fpa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_mode      (i_mode),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_push      (front_push),
        .o_op        (front_op),
        .i_q_full    (mid_full)
    );

    fpa_queue #(
        .WIDTH ($bits(t_op)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_op),
        .o_full  (mid_full),
        .i_pop   (back_pop),
        .o_data  (back_op),
        .o_empty (mid_empty)
    );

    fpa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (mid_empty),
        .i_op       (back_op),
        .o_pop      (back_pop),
        .o_push     (back_push),
        .o_res      (back_res),
        .i_out_full (out_full)
    );

    fpa_queue #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_result      = out_res.result;
    assign o_flag        = out_res.flag;
    assign o_div_by_zero = out_res.dz;

endmodule
